// File: rtl/chip8_pkg.sv
// Shared types, codes and helper functions for the CHIP-8 instruction core.
`timescale 1ns / 1ps

package chip8_pkg;

    // Item operation codes
    localparam logic [2:0] OPN_EXEC   = 3'd0;
    localparam logic [2:0] OPN_WMEM   = 3'd1;
    localparam logic [2:0] OPN_KEY    = 3'd2;
    localparam logic [2:0] OPN_TICK   = 3'd3;
    localparam logic [2:0] OPN_ROW    = 3'd4;
    localparam logic [2:0] OPN_MEMRD  = 3'd5;

    // Instruction low-byte codes
    localparam logic [7:0] LO_CLS   = 8'hE0;
    localparam logic [7:0] LO_RET   = 8'hEE;
    localparam logic [7:0] LO_EXIT  = 8'hFD;
    localparam logic [7:0] LO_SKP   = 8'h9E;
    localparam logic [7:0] LO_SKNP  = 8'hA1;
    localparam logic [7:0] LO_GDLY  = 8'h07;
    localparam logic [7:0] LO_WKEY  = 8'h0A;
    localparam logic [7:0] LO_SDLY  = 8'h15;
    localparam logic [7:0] LO_SSND  = 8'h18;
    localparam logic [7:0] LO_ADDI  = 8'h1E;
    localparam logic [7:0] LO_FONT  = 8'h29;
    localparam logic [7:0] LO_BCD   = 8'h33;
    localparam logic [7:0] LO_STOR  = 8'h55;
    localparam logic [7:0] LO_LOAD  = 8'h65;
    localparam logic [7:0] LO_SAVE  = 8'h75;
    localparam logic [7:0] LO_REST  = 8'h85;

    localparam logic [15:0] LFSR_MASK = 16'hB400;
    localparam logic [11:0] ADDR_MASK = 12'hFFF;

    typedef enum logic [1:0] {
        MODE_RUN  = 2'd0,
        MODE_WAIT = 2'd1,
        MODE_STOP = 2'd2,
        MODE_ERR  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        FLT_NONE   = 2'd0,
        FLT_OPCODE = 2'd1,
        FLT_OVER   = 2'd2,
        FLT_UNDER  = 2'd3
    } t_fault;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_F1, S_F2, S_RX, S_RY, S_EXEC, S_WX, S_RET,
        S_SPR, S_BCD, S_BLK_RD, S_BLK_WR, S_RB_MEM, S_RB_ROW, S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  operation;
        logic [11:0] mem_address;
        logic [7:0]  mem_data;
        logic [3:0]  key_id;
        logic [4:0]  row_select;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  run_mode;
        logic [1:0]  fault_code;
        logic [15:0] fault_data;
        logic [15:0] program_counter;
        logic        sound_active;
        logic [7:0]  read_byte;
        logic [63:0] display_row;
    } t_out_word;

    // Place sprite bit 7 at column x, bit 0 at column x+7, wrapping at 64.
    function automatic logic [63:0] sprite_mask(input logic [7:0] bits,
                                                input logic [5:0] x);
        logic [63:0]  s;
        logic [127:0] t;
        s = '0;
        for (int b = 0; b < 8; b++) s[7-b] = bits[b];
        t = {s, s} << x;
        return t[127:64];
    endfunction

    // Decimal digit of v: sel 0 hundreds, 1 tens, 2 ones.
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [13:0] ph;
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] pt;
        logic [3:0]  t;
        logic [6:0]  o;
        ph = 14'(v) * 14'd41;
        h  = ph[13:12];
        r  = 7'(8'(v) - 8'(h) * 8'd100);
        pt = 15'(r) * 15'd205;
        t  = pt[14:11];
        o  = r - 7'(t) * 7'd10;
        if (sel == 2'd0) return 8'(h);
        else if (sel == 2'd1) return 8'(t);
        else return 8'(o);
    endfunction

endpackage

// File: rtl/chip8_instruction_core.sv
// CHIP-8 instruction core: sequencer around main, frame, register and stack memories.
`timescale 1ns / 1ps
//
//  channel | signals                           | word type   | direction
//  --------+-----------------------------------+-------------+----------
//  input   | i_in_valid  o_in_ready  i_in_word | t_in_word   | in
//  output  | o_out_valid i_out_ready o_out_word| t_out_word  | out
//
// One item at a time. Memory writes, key presses, timer ticks and idle executes
// pass through dispatch and done; readbacks add a read state. An instruction
// fetches two bytes and reads two registers through the one-port register file
// before it executes; flag ALU ops, return, sprites row by row, BCD digits and
// block moves add states; every access waits for its memory's registered read.
// Reset (synchronous, active low) clears control state and the valid bits of
// the register, save and frame stores; main memory and stack hold garbage.
// A result waits in the output register; no new word is taken until it leaves.

module chip8_instruction_core
    import chip8_pkg::*;
#(
    parameter int MEMORY_BYTES  = 4096,
    parameter int STACK_DEPTH   = 16,
    parameter int PROGRAM_START = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int AW = $clog2(MEMORY_BYTES);
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam bit POW2 = (MEMORY_BYTES & (MEMORY_BYTES - 1)) == 0;
    localparam longint RECIP = ((64'd1 << 32) + MEMORY_BYTES - 1) / MEMORY_BYTES;

    // Reduce a 16-bit address to a memory index.
    function automatic logic [AW-1:0] mem_index(input logic [15:0] a);
        logic [39:0] p;
        logic [7:0]  q;
        logic [24:0] qm;
        logic [24:0] r;
        p  = 40'(a) * 40'(RECIP);
        q  = p[39:32];
        qm = 25'(q) * 25'(MEMORY_BYTES);
        r  = 25'(a) - qm;
        if (POW2) return a[AW-1:0];
        else return r[AW-1:0];
    endfunction

    // Memories
    logic [7:0]  main_mem  [MEMORY_BYTES];
    logic [63:0] frame_mem [32];
    logic [7:0]  rf_mem    [16];
    logic [7:0]  sv_mem    [16];
    logic [15:0] st_mem    [STACK_DEPTH];

    logic        mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd;
    logic        fr_we, fr_clr;
    logic [4:0]  fr_wa, fr_ra;
    logic [63:0] fr_wd;
    logic        rf_we;
    logic [3:0]  rf_wa, rf_ra;
    logic [7:0]  rf_wd;
    logic        sv_we;
    logic [3:0]  sv_wa, sv_ra;
    logic [7:0]  sv_wd;
    logic        st_we;
    logic [SW-1:0] st_wa, st_ra;
    logic [15:0] st_wd;

    logic [7:0]  r_mem_q;
    logic [63:0] r_fr_q;
    logic        r_fr_v;
    logic [7:0]  r_rf_q;
    logic        r_rf_v;
    logic [7:0]  r_sv_q;
    logic        r_sv_v;
    logic [15:0] r_st_q;
    logic [31:0] r_fr_vld;
    logic [15:0] r_rf_vld, r_sv_vld;

    always_ff @(posedge i_clk) begin
        if (mem_we) main_mem[mem_wa] <= mem_wd;
        r_mem_q <= main_mem[mem_ra];
        if (fr_we) frame_mem[fr_wa] <= fr_wd;
        r_fr_q <= frame_mem[fr_ra];
        if (rf_we) rf_mem[rf_wa] <= rf_wd;
        r_rf_q <= rf_mem[rf_ra];
        if (sv_we) sv_mem[sv_wa] <= sv_wd;
        r_sv_q <= sv_mem[sv_ra];
        if (st_we) st_mem[st_wa] <= st_wd;
        r_st_q <= st_mem[st_ra];
    end

    // Valid bits stand in for the zero reset of the small stores.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fr_vld <= '0;
            r_rf_vld <= '0;
            r_sv_vld <= '0;
            r_fr_v   <= 1'b0;
            r_rf_v   <= 1'b0;
            r_sv_v   <= 1'b0;
        end else begin
            r_fr_v <= r_fr_vld[fr_ra];
            r_rf_v <= r_rf_vld[rf_ra];
            r_sv_v <= r_sv_vld[sv_ra];
            if (fr_clr) r_fr_vld <= '0;
            else if (fr_we) r_fr_vld[fr_wa] <= 1'b1;
            if (rf_we) r_rf_vld[rf_wa] <= 1'b1;
            if (sv_we) r_sv_vld[sv_wa] <= 1'b1;
        end
    end

    logic [63:0] fr_val;
    logic [7:0]  rf_val, sv_val;
    assign fr_val = r_fr_v ? r_fr_q : '0;
    assign rf_val = r_rf_v ? r_rf_q : '0;
    assign sv_val = r_sv_v ? r_sv_q : '0;

    // Architectural and sequencer registers
    t_state    r_state, n_state;
    t_in_word  r_in, n_in;
    t_mode     r_mode, n_mode;
    t_fault    r_fcode, n_fcode;
    logic [15:0] r_fdata, n_fdata;
    logic [15:0] r_pc, n_pc, r_i, n_i, r_lfsr, n_lfsr;
    logic [4:0]  r_level, n_level;
    logic [7:0]  r_delay, n_delay, r_sound, n_sound;
    logic [3:0]  r_wait, n_wait;
    logic [7:0]  r_hi, n_hi, r_lo, n_lo, r_vx, n_vx, r_vy, n_vy, r_wd, n_wd;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_hit, n_hit;
    logic [7:0]  r_rb, n_rb;
    logic [63:0] r_drow, n_drow;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out, n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_RUN;
            r_fcode     <= FLT_NONE;
            r_fdata     <= '0;
            r_pc        <= 16'(PROGRAM_START);
            r_i         <= '0;
            r_lfsr      <= 16'd1;
            r_level     <= '0;
            r_delay     <= '0;
            r_sound     <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_fcode     <= n_fcode;
            r_fdata     <= n_fdata;
            r_pc        <= n_pc;
            r_i         <= n_i;
            r_lfsr      <= n_lfsr;
            r_level     <= n_level;
            r_delay     <= n_delay;
            r_sound     <= n_sound;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_hi   <= n_hi;
        r_lo   <= n_lo;
        r_vx   <= n_vx;
        r_vy   <= n_vy;
        r_wd   <= n_wd;
        r_cnt  <= n_cnt;
        r_hit  <= n_hit;
        r_rb   <= n_rb;
        r_drow <= n_drow;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Instruction fields
    logic [3:0]  w_op, w_x, w_y, w_n;
    logic [15:0] w_word, w_nnn, w_pc2;
    logic [8:0]  w_sum;
    logic [15:0] w_lfsr_next;
    logic [63:0] w_mask;
    logic        w_row_hit;
    logic [15:0] w_iaddr;

    assign w_op   = r_hi[7:4];
    assign w_x    = r_hi[3:0];
    assign w_y    = r_lo[7:4];
    assign w_n    = r_lo[3:0];
    assign w_word = {r_hi, r_lo};
    assign w_nnn  = {4'b0, w_word[11:0]};
    assign w_pc2  = r_pc + 16'd2;
    assign w_sum  = 9'(r_vx) + 9'(r_vy);
    assign w_lfsr_next = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_MASK) : (r_lfsr >> 1);
    assign w_mask = sprite_mask(r_mem_q, r_vx[5:0]);
    assign w_row_hit = |(fr_val & w_mask);
    assign w_iaddr = r_i + 16'(r_cnt);

    always_comb begin
        logic bad;
        bad = 1'b0;

        n_state = r_state;
        n_in    = r_in;
        n_mode  = r_mode;
        n_fcode = r_fcode;
        n_fdata = r_fdata;
        n_pc    = r_pc;
        n_i     = r_i;
        n_lfsr  = r_lfsr;
        n_level = r_level;
        n_delay = r_delay;
        n_sound = r_sound;
        n_wait  = r_wait;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_vx    = r_vx;
        n_vy    = r_vy;
        n_wd    = r_wd;
        n_cnt   = r_cnt;
        n_hit   = r_hit;
        n_rb    = r_rb;
        n_drow  = r_drow;
        n_out   = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = '0;
        fr_we = 1'b0; fr_clr = 1'b0; fr_wa = '0; fr_wd = '0; fr_ra = '0;
        rf_we = 1'b0; rf_wa = '0; rf_wd = '0; rf_ra = '0;
        sv_we = 1'b0; sv_wa = '0; sv_wd = '0; sv_ra = '0;
        st_we = 1'b0; st_wa = '0; st_wd = '0; st_ra = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_in    = i_in_word;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_rb    = '0;
                n_drow  = '0;
                n_state = S_DONE;
                unique case (r_in.operation)
                    OPN_EXEC: begin
                        if (r_mode == MODE_RUN) begin
                            mem_ra  = mem_index(r_pc);
                            n_state = S_F1;
                        end
                    end
                    OPN_WMEM: begin
                        mem_we = 1'b1;
                        mem_wa = mem_index(16'(r_in.mem_address));
                        mem_wd = r_in.mem_data;
                    end
                    OPN_KEY: begin
                        if (r_mode == MODE_WAIT) begin
                            rf_we  = 1'b1;
                            rf_wa  = r_wait;
                            rf_wd  = 8'(r_in.key_id);
                            n_mode = MODE_RUN;
                        end
                    end
                    OPN_TICK: begin
                        if (r_delay != '0) n_delay = r_delay - 8'd1;
                        if (r_sound != '0) n_sound = r_sound - 8'd1;
                    end
                    OPN_ROW: begin
                        fr_ra   = r_in.row_select;
                        n_state = S_RB_ROW;
                    end
                    OPN_MEMRD: begin
                        mem_ra  = mem_index(16'(r_in.mem_address));
                        n_state = S_RB_MEM;
                    end
                    default: ;
                endcase
            end
            S_RB_ROW: begin
                n_drow  = fr_val;
                n_state = S_DONE;
            end
            S_RB_MEM: begin
                n_rb    = r_mem_q;
                n_state = S_DONE;
            end
            S_F1: begin
                n_hi    = r_mem_q;
                mem_ra  = mem_index(r_pc + 16'd1);
                n_state = S_F2;
            end
            S_F2: begin
                n_lo    = r_mem_q;
                rf_ra   = r_hi[3:0];
                n_state = S_RX;
            end
            S_RX: begin
                n_vx    = rf_val;
                // Bnnn needs V0 in place of VY
                rf_ra   = (w_op == 4'hB) ? 4'h0 : w_y;
                n_state = S_RY;
            end
            S_RY: begin
                n_vy    = rf_val;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_pc    = w_pc2;
                n_state = S_DONE;
                unique case (w_op)
                    4'h0: begin
                        if (r_lo == LO_CLS) fr_clr = 1'b1;
                        else if (r_lo == LO_RET) begin
                            if (r_level == '0 || r_level > 5'(STACK_DEPTH)) begin
                                n_mode  = MODE_ERR;
                                n_fcode = FLT_UNDER;
                                n_fdata = '0;
                                n_pc    = '0;
                            end else begin
                                n_level = r_level - 5'd1;
                                st_ra   = SW'(r_level - 5'd1);
                                n_state = S_RET;
                            end
                        end else if (r_lo == LO_EXIT) n_mode = MODE_STOP;
                        else bad = 1'b1;
                    end
                    4'h1: n_pc = w_nnn;
                    4'h2: begin
                        if (r_level >= 5'(STACK_DEPTH)) begin
                            n_mode  = MODE_ERR;
                            n_fcode = FLT_OVER;
                            n_fdata = '0;
                        end else begin
                            st_we   = 1'b1;
                            st_wa   = SW'(r_level);
                            st_wd   = w_pc2;
                            n_level = r_level + 5'd1;
                        end
                        n_pc = w_nnn;
                    end
                    4'h3: if (r_vx == r_lo) n_pc = w_pc2 + 16'd2;
                    4'h4: if (r_vx != r_lo) n_pc = w_pc2 + 16'd2;
                    4'h5: if (r_vx == r_vy) n_pc = w_pc2 + 16'd2;
                    4'h6: begin
                        rf_we = 1'b1; rf_wa = w_x; rf_wd = r_lo;
                    end
                    4'h7: begin
                        rf_we = 1'b1; rf_wa = w_x; rf_wd = r_vx + r_lo;
                    end
                    4'h8: begin
                        rf_wa = w_x;
                        rf_we = 1'b1;
                        unique case (w_n)
                            4'h0: rf_wd = r_vy;
                            4'h1: rf_wd = r_vx | r_vy;
                            4'h2: rf_wd = r_vx & r_vy;
                            4'h3: rf_wd = r_vx ^ r_vy;
                            4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
                                // Flag first, result next cycle so VX wins on X = F
                                rf_wa   = 4'hF;
                                n_state = S_WX;
                                unique case (w_n)
                                    4'h4: begin
                                        rf_wd = 8'(w_sum[8]);
                                        n_wd  = w_sum[7:0];
                                    end
                                    4'h5: begin
                                        rf_wd = 8'(r_vx >= r_vy);
                                        n_wd  = r_vx - r_vy;
                                    end
                                    4'h6: begin
                                        rf_wd = 8'(r_vx[0]);
                                        n_wd  = r_vx >> 1;
                                    end
                                    4'h7: begin
                                        rf_wd = 8'(r_vy >= r_vx);
                                        n_wd  = r_vy - r_vx;
                                    end
                                    default: begin
                                        rf_wd = 8'(r_vx[7]);
                                        n_wd  = r_vx << 1;
                                    end
                                endcase
                            end
                            default: begin
                                rf_we = 1'b0;
                                bad   = 1'b1;
                            end
                        endcase
                    end
                    4'h9: if (r_vx != r_vy) n_pc = w_pc2 + 16'd2;
                    4'hA: n_i = w_nnn;
                    4'hB: n_pc = w_nnn + 16'(r_vy);
                    4'hC: begin
                        n_lfsr = w_lfsr_next;
                        rf_we  = 1'b1;
                        rf_wa  = w_x;
                        rf_wd  = w_lfsr_next[7:0] & r_lo;
                    end
                    4'hD: begin
                        if (w_n == 4'h0) begin
                            rf_we = 1'b1; rf_wa = 4'hF; rf_wd = '0;
                        end else begin
                            n_cnt   = '0;
                            n_hit   = 1'b0;
                            mem_ra  = mem_index(r_i);
                            fr_ra   = r_vy[4:0];
                            n_state = S_SPR;
                        end
                    end
                    4'hE: begin
                        if (r_lo != LO_SKP && r_lo != LO_SKNP) bad = 1'b1;
                    end
                    default: begin
                        unique case (r_lo)
                            LO_GDLY: begin
                                rf_we = 1'b1; rf_wa = w_x; rf_wd = r_delay;
                            end
                            LO_WKEY: begin
                                n_mode = MODE_WAIT;
                                n_wait = w_x;
                            end
                            LO_SDLY: n_delay = r_vx;
                            LO_SSND: n_sound = r_vx;
                            LO_ADDI: n_i = r_i + 16'(r_vx);
                            LO_FONT: n_i = 16'(r_vx) * 16'd5;
                            LO_BCD: begin
                                n_cnt   = '0;
                                n_state = S_BCD;
                            end
                            LO_STOR, LO_LOAD, LO_SAVE, LO_REST: begin
                                n_cnt   = '0;
                                n_state = S_BLK_RD;
                            end
                            default: bad = 1'b1;
                        endcase
                    end
                endcase
                if (bad) begin
                    n_mode  = MODE_ERR;
                    n_fcode = FLT_OPCODE;
                    n_fdata = w_word;
                end
            end
            S_WX: begin
                rf_we   = 1'b1;
                rf_wa   = w_x;
                rf_wd   = r_wd;
                n_state = S_DONE;
            end
            S_RET: begin
                n_pc    = r_st_q;
                n_state = S_DONE;
            end
            S_SPR: begin
                // XOR this row in, fetch the next row in the same cycle
                fr_we = 1'b1;
                fr_wa = 5'(r_vy[4:0] + 5'(r_cnt));
                fr_wd = fr_val ^ w_mask;
                n_hit = r_hit | w_row_hit;
                if (r_cnt == w_n - 4'd1) begin
                    rf_we   = 1'b1;
                    rf_wa   = 4'hF;
                    rf_wd   = 8'(r_hit | w_row_hit);
                    n_state = S_DONE;
                end else begin
                    n_cnt  = r_cnt + 4'd1;
                    mem_ra = mem_index(r_i + 16'(r_cnt) + 16'd1);
                    fr_ra  = 5'(r_vy[4:0] + 5'(r_cnt) + 5'd1);
                end
            end
            S_BCD: begin
                mem_we = 1'b1;
                mem_wa = mem_index(w_iaddr);
                mem_wd = bcd_digit(r_vx, r_cnt[1:0]);
                n_cnt  = r_cnt + 4'd1;
                if (r_cnt == 4'd2) n_state = S_DONE;
            end
            S_BLK_RD: begin
                rf_ra   = r_cnt;
                sv_ra   = r_cnt;
                mem_ra  = mem_index(w_iaddr);
                n_state = S_BLK_WR;
            end
            S_BLK_WR: begin
                unique case (r_lo)
                    LO_STOR: begin
                        mem_we = 1'b1; mem_wa = mem_index(w_iaddr); mem_wd = rf_val;
                    end
                    LO_LOAD: begin
                        rf_we = 1'b1; rf_wa = r_cnt; rf_wd = r_mem_q;
                    end
                    LO_SAVE: begin
                        sv_we = 1'b1; sv_wa = r_cnt; sv_wd = rf_val;
                    end
                    default: begin
                        rf_we = 1'b1; rf_wa = r_cnt; rf_wd = sv_val;
                    end
                endcase
                if (r_cnt == w_x) n_state = S_DONE;
                else begin
                    n_cnt   = r_cnt + 4'd1;
                    n_state = S_BLK_RD;
                end
            end
            S_DONE: begin
                // Snapshot state after the item into the output word
                n_out.run_mode        = r_mode;
                n_out.fault_code      = r_fcode;
                n_out.fault_data      = r_fdata;
                n_out.program_counter = r_pc;
                n_out.sound_active    = (r_sound != '0);
                n_out.read_byte       = r_rb;
                n_out.display_row     = r_drow;
                n_out_valid           = 1'b1;
                n_state               = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
